// File: rtl/capfnv_pkg.sv
// Shared types, constants and the FNV-1a round function for the capability tag unit.
`default_nettype none
package capfnv_pkg;

    localparam int Lanes = 4;
    localparam int KeyLen = 32;
    localparam int MsgBits = 96;
    localparam int Rounds = MsgBits / 8;

    localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
    localparam logic [63:0] FnvPrimeLow = 64'd435;
    localparam int FnvPrimeShift = 40;

    localparam logic [7:0] SecretKey [0:KeyLen-1] = '{
        8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef,
        8'hfe, 8'hdc, 8'hba, 8'h98, 8'h76, 8'h54, 8'h32, 8'h10,
        8'h55, 8'haa, 8'h55, 8'haa, 8'h00, 8'h11, 8'h22, 8'h33,
        8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99, 8'haa, 8'hbb
    };

    typedef logic [63:0] t_lane;
    typedef t_lane [Lanes-1:0] t_lanes;

    typedef struct packed {
        logic               opcode;
        logic [MsgBits-1:0] msg;
        t_lanes             given;
        t_lanes             hash;
    } t_stage;

    typedef struct packed {
        t_lanes tag;
        logic   match;
    } t_result;

    function automatic t_lane fnv_mix(input t_lane h, input logic [7:0] b);
        t_lane x;
        x = h ^ {56'd0, b};
        return (x << FnvPrimeShift) + (x * FnvPrimeLow);
    endfunction

    function automatic t_lane key_state(input logic [1:0] lane);
        t_lane h;
        h = FnvBasis + {62'd0, lane};
        for (int i = 0; i < KeyLen; i++) begin
            h = fnv_mix(h, SecretKey[i]);
        end
        return h;
    endfunction

    localparam t_lanes KeyState = {key_state(2'd3), key_state(2'd2),
                                   key_state(2'd1), key_state(2'd0)};

endpackage
`default_nettype wire

// File: rtl/capability_tag_fnv_mac_top.sv
// Top level of the keyed FNV-1a capability tag unit.
//
// The input channel (i_valid, o_ready) carries one request: an opcode, the three
// capability words and, for a verify request, the four supplied tag lanes. The
// output channel (o_valid, i_ready) returns one result per request, in order:
// four computed 64-bit tag lanes and a match flag that is set only for a verify
// request whose supplied lanes all equal the computed ones.
// The key prefix is folded into constant lane seeds, so the pipeline holds one
// stage per message byte: twelve byte stages, then a compare and output stage.
// One request can be accepted every cycle while the receiver takes results.
// Each stage holds its request until the next stage can take it,
// so when the receiver stalls the pipeline fills and o_ready falls only once
// every stage is full; nothing is dropped or repeated.
// Reset clears all valid bits; no request is in flight afterward.
`default_nettype none
module capability_tag_fnv_mac_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_cap_id,
    input  wire logic [31:0] i_cap_rights,
    input  wire logic [31:0] i_cap_owner,
    input  wire logic [63:0] i_given_tag0,
    input  wire logic [63:0] i_given_tag1,
    input  wire logic [63:0] i_given_tag2,
    input  wire logic [63:0] i_given_tag3,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_tag0,
    output logic [63:0]      o_tag1,
    output logic [63:0]      o_tag2,
    output logic [63:0]      o_tag3,
    output logic             o_tag_match
);

    capfnv_pkg::t_stage  w_stage [0:capfnv_pkg::Rounds];
    logic                w_valid [0:capfnv_pkg::Rounds];
    logic                w_ready [0:capfnv_pkg::Rounds];
    capfnv_pkg::t_result w_result;

    always_comb begin
        w_stage[0].opcode = i_opcode;
        w_stage[0].msg    = {i_cap_owner, i_cap_rights, i_cap_id};
        w_stage[0].given  = {i_given_tag3, i_given_tag2, i_given_tag1, i_given_tag0};
        w_stage[0].hash   = capfnv_pkg::KeyState;
    end

    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];

    for (genvar g = 0; g < capfnv_pkg::Rounds; g++) begin : g_round
        capfnv_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_stage[g+1])
        );
    end

    capfnv_cmp u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[capfnv_pkg::Rounds]),
        .o_ready  (w_ready[capfnv_pkg::Rounds]),
        .i_data   (w_stage[capfnv_pkg::Rounds]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_result)
    );

    assign o_tag0      = w_result.tag[0];
    assign o_tag1      = w_result.tag[1];
    assign o_tag2      = w_result.tag[2];
    assign o_tag3      = w_result.tag[3];
    assign o_tag_match = w_result.match;

endmodule
`default_nettype wire

// File: rtl/capfnv_round.sv
// One pipeline stage that folds one message byte into all four hash lanes.
`default_nettype none
module capfnv_round (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire capfnv_pkg::t_stage i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output capfnv_pkg::t_stage      o_data
);

    logic               r_valid;
    capfnv_pkg::t_stage r_data;
    capfnv_pkg::t_stage n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data     = i_data;
        n_data.msg = i_data.msg >> 8;
        for (int k = 0; k < capfnv_pkg::Lanes; k++) begin
            n_data.hash[k] = capfnv_pkg::fnv_mix(i_data.hash[k], i_data.msg[7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/capfnv_cmp.sv
// Final stage that compares the computed tag with the supplied one and holds the result.
`default_nettype none
module capfnv_cmp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire capfnv_pkg::t_stage i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output capfnv_pkg::t_result     o_result
);

    logic                r_valid;
    capfnv_pkg::t_result r_result;
    capfnv_pkg::t_result n_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_result.tag   = i_data.hash;
        n_result.match = i_data.opcode && (i_data.hash == i_data.given);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

// File: rtl/capfnv_checker.sv
// Port-level checker for the capability tag unit and its bind to the top level.
`default_nettype none
module capfnv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_tag0,
    input wire logic [63:0] o_tag1,
    input wire logic [63:0] o_tag2,
    input wire logic [63:0] o_tag3,
    input wire logic        o_tag_match
);

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("A result is offered right after reset.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tag0) && $stable(o_tag1)
            && $stable(o_tag2) && $stable(o_tag3) && $stable(o_tag_match))
        else $error("A stalled result changed or vanished.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("The unit refuses a request while its output is empty.");

    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("The unit refuses a request while the receiver takes results.");

endmodule

bind capability_tag_fnv_mac_top capfnv_checker u_checker (.*);
`default_nettype wire
